@@ rtl/cabp_pkg.sv @@
// ----------------------------------------------------------------------------
// cabp_pkg
// Shared types and constants for the clipped alpha blit pixel unit.
// ----------------------------------------------------------------------------
package cabp_pkg;

  localparam int unsigned MAX_SURFACE_DIM = 4096;

  localparam int unsigned DIM_W    = 13;  // width, height, pitch registers
  localparam int unsigned OFS_W    = 14;  // signed offsets
  localparam int unsigned COORD_W  = 12;  // source and clipped coordinates
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned PIX_W    = 32;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DIM_W-1:0] MAX_DIM   = DIM_W'(MAX_SURFACE_DIM);
  localparam logic [7:0]       ALPHA_MAX = 8'hFF;
  localparam int unsigned      ALPHA_LSB = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEST_WIDTH  = 3'd0,
    CFG_DEST_HEIGHT = 3'd1,
    CFG_ROW_PITCH   = 3'd2,
    CFG_OFFSET_X    = 3'd3,
    CFG_OFFSET_Y    = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ACT_CLIPPED = 2'd0,
    ACT_SKIP    = 2'd1,
    ACT_COPY    = 2'd2,
    ACT_BLEND   = 2'd3
  } action_t;

  // Surface geometry; width and height are held already saturated.
  typedef struct packed {
    logic        [DIM_W-1:0] width;
    logic        [DIM_W-1:0] height;
    logic        [DIM_W-1:0] pitch;
    logic signed [OFS_W-1:0] off_x;
    logic signed [OFS_W-1:0] off_y;
  } cabp_cfg_t;

  typedef struct packed {
    logic             write_enable;
    action_t          action;
    logic [PIX_W-1:0] pixel;
  } cabp_blend_res_t;

  function automatic logic [DIM_W-1:0] sat_dim(input logic [DIM_W-1:0] v);
    return (v > MAX_DIM) ? MAX_DIM : v;
  endfunction

endpackage

@@ rtl/cabp_coord.sv @@
// ----------------------------------------------------------------------------
// cabp_coord
// Offsets and clips the pixel coordinates, then forms row * pitch + column.
// Two register stages.
// ----------------------------------------------------------------------------
module cabp_coord (
  input  logic                                clk,
  input  cabp_pkg::cabp_cfg_t                 cfg,
  input  logic [cabp_pkg::COORD_W-1:0]        source_col,
  input  logic [cabp_pkg::COORD_W-1:0]        source_row,
  output logic                                clipped,
  output logic [cabp_pkg::ADDR_W-1:0]         dest_address
);

  localparam int unsigned SUM_W = cabp_pkg::OFS_W + 1;
  localparam int unsigned PROD_W = cabp_pkg::COORD_W + cabp_pkg::DIM_W;

  logic signed [SUM_W-1:0] col_s;
  logic signed [SUM_W-1:0] row_s;
  logic                    col_out;
  logic                    row_out;

  logic                         clip1_r;
  logic [cabp_pkg::COORD_W-1:0] col1_r;
  logic [cabp_pkg::COORD_W-1:0] row1_r;

  logic [PROD_W-1:0]            prod;
  logic                         clip2_r;
  logic [cabp_pkg::ADDR_W-1:0]  addr2_r;

  always_comb begin
    col_s = $signed({{(SUM_W-cabp_pkg::COORD_W){1'b0}}, source_col})
          + SUM_W'(cfg.off_x);
    row_s = $signed({{(SUM_W-cabp_pkg::COORD_W){1'b0}}, source_row})
          + SUM_W'(cfg.off_y);
    // sign bit set, or at/after the edge (width is at most 4096 here)
    col_out = col_s[SUM_W-1] ||
              ({1'b0, col_s[SUM_W-2:0]} >= SUM_W'(cfg.width));
    row_out = row_s[SUM_W-1] ||
              ({1'b0, row_s[SUM_W-2:0]} >= SUM_W'(cfg.height));
  end

  always_ff @(posedge clk) begin
    clip1_r <= col_out || row_out;
    col1_r  <= col_s[cabp_pkg::COORD_W-1:0];
    row1_r  <= row_s[cabp_pkg::COORD_W-1:0];
  end

  assign prod = PROD_W'(row1_r) * PROD_W'(cfg.pitch);

  always_ff @(posedge clk) begin
    clip2_r <= clip1_r;
    addr2_r <= prod[cabp_pkg::ADDR_W-1:0] + cabp_pkg::ADDR_W'(col1_r);
  end

  assign clipped      = clip2_r;
  assign dest_address = addr2_r;

endmodule

@@ rtl/cabp_blend.sv @@
// ----------------------------------------------------------------------------
// cabp_blend
// Source-over blend of one ARGB8888 pair: per-channel products in the first
// stage, divide by 255 and result select in the second.
// ----------------------------------------------------------------------------
module cabp_blend (
  input  logic                          clk,
  input  logic [cabp_pkg::PIX_W-1:0]    source_pixel,
  input  logic [cabp_pkg::PIX_W-1:0]    dest_pixel,
  output cabp_pkg::cabp_blend_res_t     res
);

  localparam int unsigned NCH = 3;

  logic [7:0]  alpha;
  logic [7:0]  inv_alpha;
  logic [15:0] mix [NCH];

  logic [15:0]                   mix1_r [NCH];
  cabp_pkg::action_t             act1_r;
  logic [cabp_pkg::PIX_W-1:0]    sp1_r;
  logic [cabp_pkg::PIX_W-1:0]    dp1_r;

  logic [16:0]                   qsum [NCH];
  logic [7:0]                    quo  [NCH];
  cabp_pkg::cabp_blend_res_t     res_nxt;
  cabp_pkg::cabp_blend_res_t     res2_r;

  assign alpha     = source_pixel[cabp_pkg::ALPHA_LSB +: 8];
  assign inv_alpha = cabp_pkg::ALPHA_MAX - alpha;

  // s*a + d*(255-a) never exceeds 255*255, so 16 bits hold it
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      mix[i] = 16'(source_pixel[8*i +: 8]) * 16'(alpha)
             + 16'(dest_pixel[8*i +: 8]) * 16'(inv_alpha);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NCH; i++) begin
      mix1_r[i] <= mix[i];
    end
    sp1_r <= source_pixel;
    dp1_r <= dest_pixel;
    if (alpha == '0) begin
      act1_r <= cabp_pkg::ACT_SKIP;
    end else if (alpha == cabp_pkg::ALPHA_MAX) begin
      act1_r <= cabp_pkg::ACT_COPY;
    end else begin
      act1_r <= cabp_pkg::ACT_BLEND;
    end
  end

  // x / 255 == (x + (x >> 8) + 1) >> 8, exact for x below 65535
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      qsum[i] = 17'(mix1_r[i]) + 17'(mix1_r[i][15:8]) + 17'd1;
      quo[i]  = qsum[i][15:8];
    end
    res_nxt.action = act1_r;
    case (act1_r)
      cabp_pkg::ACT_SKIP: begin
        res_nxt.write_enable = 1'b0;
        res_nxt.pixel        = dp1_r;
      end
      cabp_pkg::ACT_COPY: begin
        res_nxt.write_enable = 1'b1;
        res_nxt.pixel        = sp1_r;
      end
      default: begin
        res_nxt.write_enable = 1'b1;
        res_nxt.pixel        = {cabp_pkg::ALPHA_MAX, quo[2], quo[1], quo[0]};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    res2_r <= res_nxt;
  end

  assign res = res2_r;

endmodule

@@ rtl/clipped_alpha_blit_pixel_unit.sv @@
// ----------------------------------------------------------------------------
// clipped_alpha_blit_pixel_unit
// Clips a blit pixel to the destination, forms its word address and applies
// the source-over alpha rule against the current destination pixel.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle; busy is always low, since the three-stage
//   pipeline (offset/clip and multiply-add, address product and divide,
//   output register) never stalls.
// Reset: clears the valid pipeline and loads width 640, height 480,
//   pitch 640, offsets 0. The receiver cannot stall.
module clipped_alpha_blit_pixel_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [cabp_pkg::COORD_W-1:0]         in_source_col,
  input  logic [cabp_pkg::COORD_W-1:0]         in_source_row,
  input  logic [cabp_pkg::PIX_W-1:0]           in_source_pixel,
  input  logic [cabp_pkg::PIX_W-1:0]           in_dest_pixel,
  output logic                                 out_valid,
  output logic                                 out_write_enable,
  output logic [cabp_pkg::ADDR_W-1:0]          out_dest_address,
  output logic [cabp_pkg::PIX_W-1:0]           out_result_pixel,
  output logic [1:0]                           out_action,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cabp_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cabp_pkg::OFS_W-1:0]           cfg_data
);

  cabp_pkg::cabp_cfg_t        cfg_r;
  logic [2:0]                 vld_r;
  logic                       clipped;
  logic [cabp_pkg::ADDR_W-1:0] addr;
  cabp_pkg::cabp_blend_res_t  blend_res;

  logic                        we_r;
  logic [cabp_pkg::ADDR_W-1:0] addr_r;
  logic [cabp_pkg::PIX_W-1:0]  pix_r;
  cabp_pkg::action_t           act_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= cabp_pkg::DIM_W'(640);
      cfg_r.height <= cabp_pkg::DIM_W'(480);
      cfg_r.pitch  <= cabp_pkg::DIM_W'(640);
      cfg_r.off_x  <= '0;
      cfg_r.off_y  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cabp_pkg::CFG_DEST_WIDTH:
          cfg_r.width  <= cabp_pkg::sat_dim(cfg_data[cabp_pkg::DIM_W-1:0]);
        cabp_pkg::CFG_DEST_HEIGHT:
          cfg_r.height <= cabp_pkg::sat_dim(cfg_data[cabp_pkg::DIM_W-1:0]);
        cabp_pkg::CFG_ROW_PITCH:
          cfg_r.pitch  <= cfg_data[cabp_pkg::DIM_W-1:0];
        cabp_pkg::CFG_OFFSET_X:
          cfg_r.off_x  <= cfg_data;
        cabp_pkg::CFG_OFFSET_Y:
          cfg_r.off_y  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[1:0], start && !busy};
    end
  end

  cabp_coord u_coord (
    .clk          (clk),
    .cfg          (cfg_r),
    .source_col   (in_source_col),
    .source_row   (in_source_row),
    .clipped      (clipped),
    .dest_address (addr)
  );

  cabp_blend u_blend (
    .clk          (clk),
    .source_pixel (in_source_pixel),
    .dest_pixel   (in_dest_pixel),
    .res          (blend_res)
  );

  // clipped pixels report all-zero fields
  always_ff @(posedge clk) begin
    if (clipped) begin
      we_r   <= 1'b0;
      addr_r <= '0;
      pix_r  <= '0;
      act_r  <= cabp_pkg::ACT_CLIPPED;
    end else begin
      we_r   <= blend_res.write_enable;
      addr_r <= addr;
      pix_r  <= blend_res.pixel;
      act_r  <= blend_res.action;
    end
  end

  assign out_valid        = vld_r[2];
  assign out_write_enable = we_r;
  assign out_dest_address = addr_r;
  assign out_result_pixel = pix_r;
  assign out_action       = act_r;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Clipped alpha blit pixel unit testbench
// Sends pixel transactions and register writes into the unit. A software copy
// of the offset, clip, address and src-over blend rules predicts each result,
// and the output stream is compared in order, field by field.
// ----------------------------------------------------------------------------
module testbench;
  import cabp_pkg::*;

  localparam int PIPE_LATENCY   = 3;
  localparam int MAX_REPORTS    = 10;
  localparam int ITEMS_PER_MIX  = 150;
  localparam int NUM_MIXES      = 8;
  localparam int SRC_COORD_MAX  = (1 << COORD_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

  typedef struct {
    logic              write_enable;
    logic [ADDR_W-1:0] dest_address;
    logic [PIX_W-1:0]  pixel;
    action_t           action;
  } blit_result_t;

  // Predicts each pixel transaction and checks the results in order.
  class blit_scoreboard;
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic [DIM_W-1:0] pitch;
    int               off_x;
    int               off_y;
    blit_result_t     due_q[$];
    int               mismatches;

    function new();
      width      = DIM_W'(640);
      height     = DIM_W'(480);
      pitch      = DIM_W'(640);
      off_x      = 0;
      off_y      = 0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [OFS_W-1:0] data);
      case (idx)
        CFG_DEST_WIDTH:  width  = data[DIM_W-1:0];
        CFG_DEST_HEIGHT: height = data[DIM_W-1:0];
        CFG_ROW_PITCH:   pitch  = data[DIM_W-1:0];
        CFG_OFFSET_X:    off_x  = $signed(data);
        CFG_OFFSET_Y:    off_y  = $signed(data);
        default: ;
      endcase
    endfunction

    function logic [7:0] mix_channel(logic [7:0] s, logic [7:0] d, logic [7:0] a);
      int unsigned sum;
      sum = s * a + d * (255 - a);
      return 8'(sum / 255);
    endfunction

    function void note_pixel(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                             logic [PIX_W-1:0] sp, logic [PIX_W-1:0] dp);
      int           tc;
      int           tr;
      int           w;
      int           h;
      logic [31:0]  prod;
      logic [7:0]   alpha;
      blit_result_t r;
      tc = int'(col) + off_x;
      tr = int'(row) + off_y;
      w = (int'(width) > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : int'(width);
      h = (int'(height) > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : int'(height);
      alpha = sp[31:ALPHA_LSB];
      if (tc < 0 || tc >= w || tr < 0 || tr >= h) begin
        r = '{1'b0, '0, '0, ACT_CLIPPED};
      end else begin
        prod = tr * int'(pitch) + tc;
        r.dest_address = prod[ADDR_W-1:0];
        if (alpha == 8'h00) begin
          r.write_enable = 1'b0;
          r.pixel        = dp;
          r.action       = ACT_SKIP;
        end else if (alpha == ALPHA_MAX) begin
          r.write_enable = 1'b1;
          r.pixel        = sp;
          r.action       = ACT_COPY;
        end else begin
          r.write_enable = 1'b1;
          r.pixel = {ALPHA_MAX, mix_channel(sp[23:16], dp[23:16], alpha),
                     mix_channel(sp[15:8], dp[15:8], alpha),
                     mix_channel(sp[7:0], dp[7:0], alpha)};
          r.action = ACT_BLEND;
        end
      end
      due_q.push_back(r);
    endfunction

    function void check_result(logic we, logic [ADDR_W-1:0] addr,
                               logic [PIX_W-1:0] pix, logic [1:0] act);
      blit_result_t r;
      if (due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result we=%b addr=%h pix=%h act=%0d",
                   $realtime, we, addr, pix, act);
        return;
      end
      r = due_q.pop_front();
      if (we !== r.write_enable || addr !== r.dest_address || pix !== r.pixel ||
          act !== r.action) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: mismatch exp we=%b addr=%h pix=%h act=%0d, got we=%b addr=%h pix=%h act=%0d",
                   $realtime, r.write_enable, r.dest_address, r.pixel, r.action,
                   we, addr, pix, act);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [COORD_W-1:0]   in_source_col;
  logic [COORD_W-1:0]   in_source_row;
  logic [PIX_W-1:0]     in_source_pixel;
  logic [PIX_W-1:0]     in_dest_pixel;
  logic                 out_valid;
  logic                 out_write_enable;
  logic [ADDR_W-1:0]    out_dest_address;
  logic [PIX_W-1:0]     out_result_pixel;
  logic [1:0]           out_action;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [OFS_W-1:0]     cfg_data;

  blit_scoreboard sb = new();
  int             burst_left = 0;

  clipped_alpha_blit_pixel_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_source_col    (in_source_col),
    .in_source_row    (in_source_row),
    .in_source_pixel  (in_source_pixel),
    .in_dest_pixel    (in_dest_pixel),
    .out_valid        (out_valid),
    .out_write_enable (out_write_enable),
    .out_dest_address (out_dest_address),
    .out_result_pixel (out_result_pixel),
    .out_action       (out_action),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Sampled at the edge, so values seen are those from before the edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_reg(cfg_index, cfg_data);
      if (start && !busy)
        sb.note_pixel(in_source_col, in_source_row, in_source_pixel, in_dest_pixel);
      if (out_valid)
        sb.check_result(out_write_enable, out_dest_address, out_result_pixel, out_action);
    end
  end

  task automatic send_pixel(input logic [COORD_W-1:0] col, input logic [COORD_W-1:0] row,
                            input logic [PIX_W-1:0] sp, input logic [PIX_W-1:0] dp);
    int gap;
    // ends a run of register writes
    if (cfg_valid) cfg_valid <= 1'b0;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start           <= 1'b1;
    in_source_col   <= col;
    in_source_row   <= row;
    in_source_pixel <= sp;
    in_dest_pixel   <= dp;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // cfg_valid is left high for a following write; send_pixel drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (cfg_ready !== 1'b1);
  endtask

  task automatic write_geometry(input int w, input int h, input int p, input int ox,
                                input int oy);
    write_reg(CFG_DEST_WIDTH, OFS_W'(w));
    write_reg(CFG_DEST_HEIGHT, OFS_W'(h));
    write_reg(CFG_ROW_PITCH, OFS_W'(p));
    write_reg(CFG_OFFSET_X, OFS_W'(ox));
    write_reg(CFG_OFFSET_Y, OFS_W'(oy));
  endtask

  // Let the pipeline empty before the registers change.
  task automatic wait_idle();
    start <= 1'b0;
    burst_left = 0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Source coordinate, usually steered into the visible window, biased to its borders.
  function automatic logic [COORD_W-1:0] pick_coord(input int dim, input int ofs);
    int d;
    int tgt;
    int sc;
    d = (dim > MAX_SURFACE_DIM) ? MAX_SURFACE_DIM : dim;
    if (d == 0 || $urandom_range(0, 4) == 0) return COORD_W'($urandom());
    case ($urandom_range(0, 5))
      0:       tgt = 0;
      1:       tgt = d - 1;
      2:       tgt = -1;
      3:       tgt = d;
      default: tgt = $urandom_range(0, d - 1);
    endcase
    sc = tgt - ofs;
    if (sc < 0 || sc > SRC_COORD_MAX) sc = $urandom_range(0, SRC_COORD_MAX);
    return COORD_W'(sc);
  endfunction

  task automatic random_pixel();
    logic [7:0]       alpha;
    logic [PIX_W-1:0] raw;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    case ($urandom_range(0, 7))
      0:       alpha = 8'h00;
      1:       alpha = ALPHA_MAX;
      2:       alpha = 8'h01;
      3:       alpha = 8'hFE;
      default: alpha = 8'($urandom());
    endcase
    raw = $urandom();
    col = pick_coord(int'(sb.width), sb.off_x);
    row = pick_coord(int'(sb.height), sb.off_y);
    send_pixel(col, row, {alpha, raw[23:0]}, $urandom());
  endtask

  function automatic int random_dim();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 16);
      1:       return $urandom_range(4097, 16383);   // top bit dropped; saturates if still above 4096
      2:       return MAX_SURFACE_DIM;
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  function automatic int random_offset();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 16383);       // full 14 bit pattern
      1:       return -int'($urandom_range(0, 64));
      default: return $urandom_range(0, 64);
    endcase
  endfunction

  initial begin
    int w;
    rst_n           <= 1'b0;
    start           <= 1'b0;
    in_source_col   <= '0;
    in_source_row   <= '0;
    in_source_pixel <= '0;
    in_dest_pixel   <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= CFG_DEST_WIDTH;
    cfg_data        <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset geometry: corners, clipping at the right and bottom edges, every action, alpha extremes
    send_pixel(12'd0, 12'd0, 32'h0012_3456, 32'hA5A5_A5A5);
    send_pixel(12'd639, 12'd479, 32'hFF00_FF00, 32'h0000_0000);
    send_pixel(12'd640, 12'd0, 32'hFF12_3456, 32'h1111_1111);
    send_pixel(12'd0, 12'd480, 32'h8012_3456, 32'h2222_2222);
    send_pixel(12'd4095, 12'd4095, 32'h0000_0000, 32'hFFFF_FFFF);
    send_pixel(12'd1, 12'd1, 32'h01FF_FFFF, 32'h0000_0000);
    send_pixel(12'd2, 12'd2, 32'hFE00_0000, 32'hFFFF_FFFF);
    send_pixel(12'd3, 12'd3, 32'h80FF_00FF, 32'h0000_FF00);
    send_pixel(12'd10, 12'd20, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pixel(12'd5, 12'd5, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    // Oversized dimensions saturate; largest pitch wraps the address
    write_geometry(16383, 16383, 16383, 0, 0);
    send_pixel(12'd4095, 12'd4095, 32'hC0AB_CDEF, 32'h1234_5678);
    send_pixel(12'd4095, 12'd0, 32'hFF00_00FF, 32'h0);
    send_pixel(12'd0, 12'd4095, 32'h00FF_FFFF, 32'h8765_4321);
    wait_idle();

    // Zero width, then zero height: everything clips
    write_geometry(0, 1, 0, 0, 0);
    send_pixel(12'd0, 12'd0, 32'hFF00_0000, 32'h0);
    wait_idle();
    write_geometry(1, 0, 0, 0, 0);
    send_pixel(12'd0, 12'd0, 32'hFF00_0000, 32'h0);
    wait_idle();

    // Offset extremes, zero pitch, and a write to an unused register index
    write_geometry(MAX_SURFACE_DIM, MAX_SURFACE_DIM, 0, -8192, 8191);
    send_pixel(12'd4095, 12'd0, 32'hFF00_0000, 32'h0);
    wait_idle();
    write_geometry(MAX_SURFACE_DIM, MAX_SURFACE_DIM, 0, -4095, -4095);
    write_reg(CFG_UNUSED_IDX, 14'h3FFF);
    send_pixel(12'd4095, 12'd4095, 32'h40FF_8000, 32'h0000_80FF);
    send_pixel(12'd4094, 12'd4095, 32'hFF00_0000, 32'h0);
    wait_idle();
    write_geometry(MAX_SURFACE_DIM, MAX_SURFACE_DIM, 7, 4095, 4095);
    send_pixel(12'd0, 12'd0, 32'hFF12_3456, 32'h0);
    send_pixel(12'd1, 12'd0, 32'hFF12_3456, 32'h0);
    wait_idle();

    for (int m = 0; m < NUM_MIXES; m++) begin
      w = random_dim();
      write_geometry(w, random_dim(),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383) : w,
                     random_offset(), random_offset());
      if (m == 0) write_reg(CFG_UNUSED_IDX, OFS_W'($urandom()));
      repeat (ITEMS_PER_MIX) random_pixel();
      wait_idle();
    end

    if (sb.due_q.size() != 0)
      $display("%0d results never arrived", sb.due_q.size());
    if (sb.mismatches == 0 && sb.due_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
